### rtl/lbgd_pkg.sv
// Shared types, decode windows and register codes of the ladder button gesture detector.
package lbgd_pkg;

  // Button state codes, ordered so that a pair ranks above any single button
  typedef enum logic [2:0] {
    ST_NONE = 3'd0,
    ST_B1   = 3'd1,
    ST_B2   = 3'd2,
    ST_B3   = 3'd3,
    ST_B12  = 3'd4,
    ST_B13  = 3'd5,
    ST_B23  = 3'd6
  } state_e;

  localparam int LevelW    = 10;
  localparam int TimeW     = 32;
  localparam int HoldW     = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int NumWindows = 7;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOARD_VARIANT = 3'd0,
    CFG_DOUBLE_CLICK  = 3'd1,
    CFG_LONG_HOLD     = 3'd2,
    CFG_PAIR_HOLD     = 3'd3,
    CFG_SWITCH_HOLD   = 3'd4
  } cfg_idx_e;

  localparam logic [HoldW-1:0] DoubleClickRst = 16'd400;
  localparam logic [HoldW-1:0] LongHoldRst    = 16'd2000;
  localparam logic [HoldW-1:0] PairHoldRst    = 16'd500;
  localparam logic [HoldW-1:0] SwitchHoldRst  = 16'd3000;

  // One decode window: inclusive level range and the state it maps to
  typedef struct packed {
    logic [LevelW-1:0] lo;
    logic [LevelW-1:0] hi;
    state_e            code;
  } window_t;

  // Advanced board windows, first match wins
  localparam window_t AdvTable [NumWindows] = '{
    '{10'd0,   10'd100, ST_NONE},
    '{10'd260, 10'd300, ST_B3},
    '{10'd315, 10'd355, ST_B2},
    '{10'd377, 10'd405, ST_B23},
    '{10'd406, 10'd435, ST_B1},
    '{10'd470, 10'd502, ST_B13},
    '{10'd503, 10'd650, ST_B12}
  };

  // Basic board windows, first match wins (808 to 842 resolves to b1+3)
  localparam window_t BasicTable [NumWindows] = '{
    '{10'd0,   10'd100, ST_NONE},
    '{10'd490, 10'd534, ST_B3},
    '{10'd592, 10'd636, ST_B2},
    '{10'd747, 10'd791, ST_B23},
    '{10'd661, 10'd705, ST_B1},
    '{10'd798, 10'd842, ST_B13},
    '{10'd808, 10'd900, ST_B12}
  };

  // Configuration register set
  typedef struct packed {
    logic             basic_board;
    logic [HoldW-1:0] double_click_ms;
    logic [HoldW-1:0] long_hold_ms;
    logic [HoldW-1:0] pair_hold_ms;
    logic [HoldW-1:0] switch_hold_ms;
  } cfg_t;

  // One result item
  typedef struct packed {
    state_e           decoded_button;
    logic             gesture_done;
    state_e           held_state;
    logic [TimeW-1:0] press_ms;
    logic             press_active;
    logic             long_press;
    logic             pair_hold;
    logic             switch_hold;
    logic             double_click;
  } res_t;

endpackage

### rtl/ladder_button_gesture_detector.sv
// Top level of the ladder button gesture detector: input stage, core and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | ladder_level_i, time_ms_i
//  out     | source    | out_valid_o / out_stall_i | decoded_button_o .. double_click_o
//  cfg     | sink      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while out_stall_i is low; a taken item passes through the input register,
// then decode and press update into the result register.
// Reset clears the press state and loads the default hold and click times.
// A stalled result holds in the output register; the input register still takes one
// more item, and in_stall_o rises only when both registers are full.
module ladder_button_gesture_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lbgd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lbgd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [9:0]                    ladder_level_i,
  input  logic [31:0]                   time_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    decoded_button_o,
  output logic                          gesture_done_o,
  output logic [2:0]                    held_state_o,
  output logic [31:0]                   press_ms_o,
  output logic                          press_active_o,
  output logic                          long_press_o,
  output logic                          pair_hold_o,
  output logic                          switch_hold_o,
  output logic                          double_click_o
);

  lbgd_pkg::cfg_t                 cfg;
  lbgd_pkg::state_e               reading;
  lbgd_pkg::res_t                 res, res_q;
  logic                           in_valid_q, in_valid_d;
  logic                           out_valid_q, out_valid_d;
  logic [lbgd_pkg::LevelW-1:0]    level_q;
  logic [lbgd_pkg::TimeW-1:0]     time_q;
  logic                           in_take, advance, step;

  lbgd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: move the held item on whenever the result register is free
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_take ? 1'b1 : (step ? 1'b0 : in_valid_q);
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input item
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      level_q <= ladder_level_i;
      time_q  <= time_ms_i;
    end
  end

  lbgd_decode u_decode (
    .level_i       (level_q),
    .basic_board_i (cfg.basic_board),
    .reading_o     (reading)
  );

  lbgd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .reading_i (reading),
    .now_i     (time_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Hold the result item
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign decoded_button_o = res_q.decoded_button;
  assign gesture_done_o   = res_q.gesture_done;
  assign held_state_o     = res_q.held_state;
  assign press_ms_o       = res_q.press_ms;
  assign press_active_o   = res_q.press_active;
  assign long_press_o     = res_q.long_press;
  assign pair_hold_o      = res_q.pair_hold;
  assign switch_hold_o    = res_q.switch_hold;
  assign double_click_o   = res_q.double_click;

  // A release is seen only on a none reading and ends the press
  a_release_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gesture_done_o |->
      decoded_button_o == lbgd_pkg::ST_NONE && !press_active_o)
    else $error("release item with a button reading or an open press");

  // A double click only comes with a release
  a_dbl_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && double_click_o |-> gesture_done_o)
    else $error("double click without a release");

  // The pair flag needs an open press whose peak is a pair
  a_pair_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_hold_o |-> press_active_o &&
      (held_state_o == lbgd_pkg::ST_B12 || held_state_o == lbgd_pkg::ST_B13 ||
       held_state_o == lbgd_pkg::ST_B23))
    else $error("pair flag without a held pair");

  // The input side stalls only behind a stalled, full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result register can move");

endmodule

### rtl/lbgd_cfg.sv
// Configuration registers of the ladder button gesture detector.
module lbgd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lbgd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lbgd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output lbgd_pkg::cfg_t                   cfg_o
);

  lbgd_pkg::cfg_t cfg_d, cfg_q;

  // Decode the write; the board variant keeps only bit 0 of the write data
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lbgd_pkg::CFG_BOARD_VARIANT: cfg_d.basic_board     = cfg_wdata_i[0];
        lbgd_pkg::CFG_DOUBLE_CLICK:  cfg_d.double_click_ms = cfg_wdata_i;
        lbgd_pkg::CFG_LONG_HOLD:     cfg_d.long_hold_ms    = cfg_wdata_i;
        lbgd_pkg::CFG_PAIR_HOLD:     cfg_d.pair_hold_ms    = cfg_wdata_i;
        lbgd_pkg::CFG_SWITCH_HOLD:   cfg_d.switch_hold_ms  = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.basic_board     <= 1'b0;
      cfg_q.double_click_ms <= lbgd_pkg::DoubleClickRst;
      cfg_q.long_hold_ms    <= lbgd_pkg::LongHoldRst;
      cfg_q.pair_hold_ms    <= lbgd_pkg::PairHoldRst;
      cfg_q.switch_hold_ms  <= lbgd_pkg::SwitchHoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/lbgd_decode.sv
// Level-to-button decoder over the first-match window tables.
module lbgd_decode (
  input  logic [lbgd_pkg::LevelW-1:0] level_i,
  input  logic                        basic_board_i,
  output lbgd_pkg::state_e            reading_o
);

  lbgd_pkg::window_t win;

  // Walk the table from the back so the first matching window wins
  always_comb begin
    reading_o = lbgd_pkg::ST_NONE;
    win       = lbgd_pkg::AdvTable[0];
    for (int i = lbgd_pkg::NumWindows - 1; i >= 0; i--) begin
      win = basic_board_i ? lbgd_pkg::BasicTable[i] : lbgd_pkg::AdvTable[i];
      if (level_i >= win.lo && level_i <= win.hi) begin
        reading_o = win.code;
      end
    end
  end

endmodule

### rtl/lbgd_core.sv
// Press tracking state, release report and one-shot hold flags.
module lbgd_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  lbgd_pkg::state_e           reading_i,
  input  logic [lbgd_pkg::TimeW-1:0] now_i,
  input  lbgd_pkg::cfg_t             cfg_i,
  output lbgd_pkg::res_t             res_o
);

  localparam int TimeW = lbgd_pkg::TimeW;
  localparam int HoldW = lbgd_pkg::HoldW;

  lbgd_pkg::state_e   prior_q, prior_d;
  lbgd_pkg::state_e   peak_q, peak_d;
  logic               pressing_q, pressing_d;
  logic [TimeW-1:0]   start_q, start_d;
  logic [TimeW-1:0]   dur_q, dur_d;
  logic               long_sent_q, long_sent_d;
  logic               pair_sent_q, pair_sent_d;
  logic               switch_sent_q, switch_sent_d;
  logic [TimeW-1:0]   rel_time_q, rel_time_d;
  lbgd_pkg::state_e   rel_btn_q, rel_btn_d;

  logic               same, start, hold_on, release_now, single, pair;
  logic [TimeW-1:0]   held, gap;
  logic               dbl, f_long, f_pair, f_switch;

  // True once a wrapped 32-bit elapsed time reaches a 16-bit limit
  function automatic logic reached(logic [TimeW-1:0] elapsed, logic [HoldW-1:0] lim);
    return (elapsed[TimeW-1:HoldW] != '0) || (elapsed[HoldW-1:0] >= lim);
  endfunction

  // Classify this reading against the previous one
  assign same        = (reading_i == prior_q);
  assign start       = same && (reading_i != lbgd_pkg::ST_NONE) && !pressing_q;
  assign hold_on     = same && (reading_i != lbgd_pkg::ST_NONE) && pressing_q;
  assign release_now = same && (reading_i == lbgd_pkg::ST_NONE) && pressing_q;
  assign single      = (peak_q == lbgd_pkg::ST_B1) || (peak_q == lbgd_pkg::ST_B2) ||
                       (peak_q == lbgd_pkg::ST_B3);
  assign gap         = now_i - rel_time_q;

  // Advance the press state
  always_comb begin
    prior_d       = reading_i;
    peak_d        = peak_q;
    pressing_d    = pressing_q;
    start_d       = start_q;
    dur_d         = dur_q;
    long_sent_d   = long_sent_q;
    pair_sent_d   = pair_sent_q;
    switch_sent_d = switch_sent_q;
    rel_time_d    = rel_time_q;
    rel_btn_d     = rel_btn_q;
    dbl           = 1'b0;
    if (start) begin
      pressing_d    = 1'b1;
      peak_d        = reading_i;
      start_d       = now_i;
      long_sent_d   = 1'b0;
      pair_sent_d   = 1'b0;
      switch_sent_d = 1'b0;
    end else if (hold_on) begin
      if (reading_i > peak_q) begin
        peak_d = reading_i;
      end
    end else if (release_now) begin
      dur_d      = now_i - start_q;
      pressing_d = 1'b0;
      if (single) begin
        dbl        = (peak_q == rel_btn_q) && (gap[TimeW-1:HoldW] == '0) &&
                     (gap[HoldW-1:0] <= cfg_i.double_click_ms);
        rel_btn_d  = peak_q;
        rel_time_d = now_i;
      end
    end
  end

  // Fire the one-shot hold flags after the press update
  assign held = now_i - start_d;
  assign pair = (peak_d == lbgd_pkg::ST_B12) || (peak_d == lbgd_pkg::ST_B13) ||
                (peak_d == lbgd_pkg::ST_B23);

  always_comb begin
    f_long   = pressing_d && !long_sent_d && reached(held, cfg_i.long_hold_ms);
    f_pair   = pressing_d && !pair_sent_d && pair && reached(held, cfg_i.pair_hold_ms);
    f_switch = pressing_d && !switch_sent_d && (peak_d == lbgd_pkg::ST_B12) &&
               reached(held, cfg_i.switch_hold_ms);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q       <= lbgd_pkg::ST_NONE;
      peak_q        <= lbgd_pkg::ST_NONE;
      pressing_q    <= 1'b0;
      start_q       <= '0;
      dur_q         <= '0;
      long_sent_q   <= 1'b0;
      pair_sent_q   <= 1'b0;
      switch_sent_q <= 1'b0;
      rel_time_q    <= '0;
      rel_btn_q     <= lbgd_pkg::ST_NONE;
    end else if (step_i) begin
      prior_q       <= prior_d;
      peak_q        <= peak_d;
      pressing_q    <= pressing_d;
      start_q       <= start_d;
      dur_q         <= dur_d;
      long_sent_q   <= long_sent_d | f_long;
      pair_sent_q   <= pair_sent_d | f_pair;
      switch_sent_q <= switch_sent_d | f_switch;
      rel_time_q    <= rel_time_d;
      rel_btn_q     <= rel_btn_d;
    end
  end

  // Assemble the result item
  always_comb begin
    res_o.decoded_button = reading_i;
    res_o.gesture_done   = release_now;
    res_o.held_state     = peak_d;
    res_o.press_ms       = dur_d;
    res_o.press_active   = pressing_d;
    res_o.long_press     = f_long;
    res_o.pair_hold      = f_pair;
    res_o.switch_hold    = f_switch;
    res_o.double_click   = dbl;
  end

endmodule
